>>> rtl/rrd_pkg.sv
package rrd_pkg;

  // Fixed field widths of the request and result items.
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 13;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 14;
  localparam int RECLEN_W = 16;

  // Largest record span, (max_frame + 4 + 7) & ~3, with a 13-bit maximum.
  localparam int MAX_SPAN = ((2 ** LEN_W) - 1 + 11) & ~3;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_FRAME = 1'b0;
  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 13'd1514;

  // Header checks.
  localparam logic [BYTE_W-1:0] STATUS_LOW_OK = 8'h01;
  localparam logic [RECLEN_W-1:0] CRC_BYTES = 16'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_LEN0    = 3'd2,
    PH_LEN1    = 3'd3,
    PH_BODY    = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ring_byte;
    logic              restart;
  } in_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  payload_length;
    logic [LEN_W-1:0]  next_offset;
    logic [LEN_W-1:0]  read_pointer;
  } out_res_t;

endpackage

>>> rtl/rrd_regs.sv
module rrd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rrd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rrd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rrd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [rrd_pkg::LEN_W-1:0]        max_frame_bytes
);

  logic [rrd_pkg::LEN_W-1:0]        max_frame_r;
  logic [rrd_pkg::LEN_W-1:0]        max_frame_nxt;
  logic [rrd_pkg::CFG_ADDR_W-3:0]   reg_idx;
  logic                             wr_en;

  assign reg_idx = paddr[rrd_pkg::CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    max_frame_nxt = max_frame_r;
    if (wr_en && (reg_idx == rrd_pkg::REG_MAX_FRAME)) begin
      max_frame_nxt = pwdata[rrd_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= rrd_pkg::MAX_FRAME_RESET;
    end else begin
      max_frame_r <= max_frame_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == rrd_pkg::REG_MAX_FRAME) begin
      prdata = rrd_pkg::CFG_DATA_W'(max_frame_r);
    end
  end

  assign max_frame_bytes = max_frame_r;

endmodule

>>> rtl/rrd_parse.sv
module rrd_parse #(
  parameter int RING_BYTES     = 8192,
  parameter int POINTER_OFFSET = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  logic                       step,
  input  rrd_pkg::in_req_t           item,
  input  logic [rrd_pkg::LEN_W-1:0]  max_frame_bytes,
  output logic                       res_valid,
  output rrd_pkg::out_res_t          res
);

  localparam int RW     = $clog2(RING_BYTES);
  localparam int SW     = ((RW > rrd_pkg::COUNT_W) ? RW : rrd_pkg::COUNT_W) + 1;
  localparam int NSUB   = (rrd_pkg::MAX_SPAN + RING_BYTES - 1) / RING_BYTES;
  localparam int BACK   = POINTER_OFFSET % RING_BYTES;
  localparam logic [SW-1:0] RING = SW'(RING_BYTES);
  localparam logic [SW-1:0] RING_BACK = SW'(RING_BYTES - BACK);
  localparam logic [RW-1:0] ALIGN = {{(RW-2){1'b1}}, 2'b00};

  rrd_pkg::phase_t                 phase_r, phase_nxt;
  logic [rrd_pkg::COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rrd_pkg::BYTE_W-1:0]      stat_lo_r, stat_lo_nxt;
  logic [rrd_pkg::BYTE_W-1:0]      stat_hi_r, stat_hi_nxt;
  logic [rrd_pkg::BYTE_W-1:0]      len_lo_r, len_lo_nxt;
  logic [rrd_pkg::COUNT_W-1:0]     plen_r, plen_nxt;
  logic [rrd_pkg::COUNT_W-1:0]     span_r, span_nxt;
  logic [RW-1:0]                   nxt_off_r, nxt_off_nxt;
  logic [RW-1:0]                   start_r, start_nxt;

  logic [rrd_pkg::RECLEN_W-1:0]    rec_len;
  logic [rrd_pkg::RECLEN_W:0]      len_limit;
  logic                            hdr_bad;
  logic [rrd_pkg::COUNT_W-1:0]     len14;
  logic [rrd_pkg::COUNT_W-1:0]     span4;
  logic [rrd_pkg::COUNT_W-1:0]     span8;
  logic [SW-1:0]                   wrap_sum;
  logic [RW-1:0]                   nxt_calc;
  logic [rrd_pkg::COUNT_W-1:0]     cnt_inc;
  logic                            in_payload;
  logic                            body_done;
  logic [SW-1:0]                   rp_sum;
  logic [RW-1:0]                   rp_calc;

  // Header decode, valid when the fourth header byte is present.
  assign rec_len   = {item.ring_byte, len_lo_r};
  assign len_limit = (rrd_pkg::RECLEN_W + 1)'(max_frame_bytes) + 17'd4;
  assign hdr_bad   = (stat_lo_r != rrd_pkg::STATUS_LOW_OK) || (stat_hi_r == '0) ||
                     ((rrd_pkg::RECLEN_W + 1)'(rec_len) > len_limit) ||
                     (rec_len < rrd_pkg::CRC_BYTES);
  assign len14     = rec_len[rrd_pkg::COUNT_W-1:0];
  assign span4     = (len14 + 14'd3) & ~14'd3;
  assign span8     = (len14 + 14'd7) & ~14'd3;

  // Wrap of the next header offset; the span can cover several ring lengths.
  always_comb begin
    wrap_sum = SW'(start_r) + SW'(span8);
    for (int k = 0; k < NSUB; k++) begin
      if (wrap_sum >= RING) begin
        wrap_sum = wrap_sum - RING;
      end
    end
    nxt_calc = wrap_sum[RW-1:0] & ALIGN;
  end

  // Body progress and the read pointer for the record-done result.
  assign cnt_inc    = cnt_r + 14'd1;
  assign in_payload = (cnt_r < plen_r);
  assign body_done  = !in_payload && (cnt_inc >= span_r);
  assign rp_sum     = SW'(nxt_off_r) + RING_BACK;
  assign rp_calc    = ((rp_sum >= RING) ? RW'(rp_sum - RING) : RW'(rp_sum)) & ALIGN;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (item.restart) begin
      phase_nxt = rrd_pkg::PH_HDR0;
    end else begin
      unique case (phase_r)
        rrd_pkg::PH_HDR0:    phase_nxt = rrd_pkg::PH_HDR1;
        rrd_pkg::PH_HDR1:    phase_nxt = rrd_pkg::PH_LEN0;
        rrd_pkg::PH_LEN0:    phase_nxt = rrd_pkg::PH_LEN1;
        rrd_pkg::PH_LEN1:    phase_nxt = hdr_bad ? rrd_pkg::PH_DISCARD : rrd_pkg::PH_BODY;
        rrd_pkg::PH_BODY:    phase_nxt = body_done ? rrd_pkg::PH_HDR0 : rrd_pkg::PH_BODY;
        rrd_pkg::PH_DISCARD: phase_nxt = rrd_pkg::PH_DISCARD;
        default:             phase_nxt = rrd_pkg::PH_HDR0;
      endcase
    end
  end

  // Datapath state.
  always_comb begin
    cnt_nxt     = cnt_r;
    stat_lo_nxt = stat_lo_r;
    stat_hi_nxt = stat_hi_r;
    len_lo_nxt  = len_lo_r;
    plen_nxt    = plen_r;
    span_nxt    = span_r;
    nxt_off_nxt = nxt_off_r;
    start_nxt   = start_r;
    if (item.restart) begin
      cnt_nxt   = '0;
      start_nxt = '0;
    end else begin
      unique case (phase_r)
        rrd_pkg::PH_HDR0: stat_lo_nxt = item.ring_byte;
        rrd_pkg::PH_HDR1: stat_hi_nxt = item.ring_byte;
        rrd_pkg::PH_LEN0: len_lo_nxt  = item.ring_byte;
        rrd_pkg::PH_LEN1: begin
          cnt_nxt     = '0;
          plen_nxt    = len14 - 14'd4;
          span_nxt    = span4;
          nxt_off_nxt = nxt_calc;
        end
        rrd_pkg::PH_BODY: begin
          cnt_nxt = cnt_inc;
          if (body_done) begin
            cnt_nxt   = '0;
            start_nxt = nxt_off_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Result for the present item.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (item_valid && !item.restart) begin
      unique case (phase_r)
        rrd_pkg::PH_LEN1: begin
          if (hdr_bad) begin
            res_valid = 1'b1;
            res.kind  = rrd_pkg::KIND_ERROR;
          end
        end
        rrd_pkg::PH_BODY: begin
          if (in_payload) begin
            res_valid        = 1'b1;
            res.kind         = rrd_pkg::KIND_PAYLOAD;
            res.payload_byte = item.ring_byte;
            res.last_byte    = (cnt_inc == plen_r);
          end else if (body_done) begin
            res_valid          = 1'b1;
            res.kind           = rrd_pkg::KIND_DONE;
            res.payload_length = rrd_pkg::LEN_W'(plen_r);
            res.next_offset    = rrd_pkg::LEN_W'(nxt_off_r);
            res.read_pointer   = rrd_pkg::LEN_W'(rp_calc);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rrd_pkg::PH_HDR0;
      cnt_r     <= '0;
      stat_lo_r <= '0;
      stat_hi_r <= '0;
      len_lo_r  <= '0;
      plen_r    <= '0;
      span_r    <= '0;
      nxt_off_r <= '0;
      start_r   <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      stat_lo_r <= stat_lo_nxt;
      stat_hi_r <= stat_hi_nxt;
      len_lo_r  <= len_lo_nxt;
      plen_r    <= plen_nxt;
      span_r    <= span_nxt;
      nxt_off_r <= nxt_off_nxt;
      start_r   <= start_nxt;
    end
  end

endmodule

>>> rtl/rx_ring_record_deframer_top.sv
// Receive ring record deframer.
// The input channel (in_valid, in_stall, in_data) carries one ring byte per
// request, in ring order, or a restart request that returns the ring offset to
// zero and waits for a new record header. The result channel (out_valid,
// out_stall, out_data) carries payload bytes with the CRC removed and the last
// byte marked, a record-done request with the payload length, the next header
// offset and the device read pointer value, or a record-error request.
// After an error every byte is dropped until a restart request arrives.
// A request accepted into the input register has its result, if any, registered
// in the result register, which drives out_data, when the parser steps on it.
// Throughput is one request per cycle unless the receiver stalls, set by the single
// input register and the single result register around the parsing logic.
// When the receiver stalls, the held result stays on out_data, the next
// request already accepted waits in the input register, and in_stall rises
// only once that waiting request also needs the result register.
// The APB port (psel ... pready) holds max_frame_bytes at byte address 0.
// Synchronous reset clears both channels, restores max_frame_bytes to 1514
// and returns the parser to the first header byte at ring offset zero.
module rx_ring_record_deframer_top #(
  parameter int RING_BYTES     = 8192,
  parameter int POINTER_OFFSET = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rrd_pkg::in_req_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rrd_pkg::out_res_t                out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rrd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rrd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rrd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [rrd_pkg::LEN_W-1:0] max_frame_bytes;

  // Input register: holds one accepted request until the parser takes it.
  logic              item_v_r, item_v_nxt;
  rrd_pkg::in_req_t  item_r, item_nxt;

  // Result register toward the receiver.
  logic              res_v_r, res_v_nxt;
  rrd_pkg::out_res_t res_r, res_nxt;

  logic              res_valid;
  rrd_pkg::out_res_t res;
  logic              slot_free;
  logic              step;

  rrd_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_frame_bytes (max_frame_bytes)
  );

  rrd_parse #(
    .RING_BYTES     (RING_BYTES),
    .POINTER_OFFSET (POINTER_OFFSET)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_v_r),
    .step            (step),
    .item            (item_r),
    .max_frame_bytes (max_frame_bytes),
    .res_valid       (res_valid),
    .res             (res)
  );

  // The result register can take a new result when it is empty or drains now.
  // A request that makes no result moves on even while the receiver stalls.
  assign slot_free = !res_v_r || !out_stall;
  assign step      = item_v_r && (!res_valid || slot_free);
  assign in_stall  = item_v_r && !step;

  always_comb begin
    item_v_nxt = item_v_r;
    item_nxt   = item_r;
    if (!in_stall) begin
      item_v_nxt = in_valid;
      item_nxt   = in_data;
    end
  end

  always_comb begin
    res_v_nxt = res_v_r;
    res_nxt   = res_r;
    if (slot_free) begin
      res_v_nxt = step && res_valid;
      res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      res_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      res_v_r  <= res_v_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

endmodule

>>> bench/testbench.sv
module testbench;

  // Ring geometry handed to the block, kept here so the predictor uses the same values.
  localparam int RING_SIZE   = 8192;
  localparam int PTR_BACKOFF = 16;

  // One pending request for the input side, with the idle cycles to spend before it.
  typedef struct {
    rrd_pkg::in_req_t req;
    int               gap;
  } ring_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  rrd_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rrd_pkg::out_res_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rrd_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [rrd_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [rrd_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // Requests waiting to be offered, and results the deframer is predicted to produce.
  ring_item_t ring_q[$];
  rrd_pkg::out_res_t frame_exp_q[$];

  // Shadow copy of the parser state and of the frame size limit.
  rrd_pkg::phase_t ph;
  int unsigned body_cnt;
  logic [7:0] hdr_lo;
  logic [7:0] hdr_hi;
  logic [15:0] rec_len;
  logic [12:0] rec_base;
  logic [12:0] max_frame = rrd_pkg::MAX_FRAME_RESET;

  int mismatches = 0;
  int stim_count = 0;
  int held_cycles = 0;
  int stall_left = 0;
  // When set, neither side inserts idle cycles, which gives long back-to-back stretches.
  bit calm = 1'b0;

  rx_ring_record_deframer_top #(
    .RING_BYTES(RING_SIZE),
    .POINTER_OFFSET(PTR_BACKOFF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle cycles for one request or one result. At least half of the draws are zero so
  // that short bursts without gaps show up even outside the calm phase.
  function automatic int pick_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Advances the shadow parser by one accepted request and queues the result it causes.
  function automatic void predict_deframe(rrd_pkg::in_req_t req);
    rrd_pkg::out_res_t res;
    int unsigned plen, span, idx, nxt, rp;
    res = '0;
    if (req.restart) begin
      // A restart drops whatever record was in progress and rewinds the ring offset.
      ph = rrd_pkg::PH_HDR0;
      body_cnt = 0;
      rec_base = '0;
      return;
    end
    case (ph)
      rrd_pkg::PH_HDR0: begin
        hdr_lo = req.ring_byte;
        ph = rrd_pkg::PH_HDR1;
      end
      rrd_pkg::PH_HDR1: begin
        hdr_hi = req.ring_byte;
        ph = rrd_pkg::PH_LEN0;
      end
      rrd_pkg::PH_LEN0: begin
        rec_len = {8'h00, req.ring_byte};
        ph = rrd_pkg::PH_LEN1;
      end
      rrd_pkg::PH_LEN1: begin
        rec_len[15:8] = req.ring_byte;
        body_cnt = 0;
        // The status low byte must be exactly one, the high byte nonzero, and the
        // length must cover the CRC without exceeding the frame limit plus the CRC.
        if (hdr_lo != rrd_pkg::STATUS_LOW_OK || hdr_hi == 8'h00 ||
            rec_len > max_frame + 16'd4 || rec_len < rrd_pkg::CRC_BYTES) begin
          ph = rrd_pkg::PH_DISCARD;
          res.kind = rrd_pkg::KIND_ERROR;
          frame_exp_q.push_back(res);
        end else begin
          ph = rrd_pkg::PH_BODY;
        end
      end
      rrd_pkg::PH_BODY: begin
        plen = rec_len - 4;
        span = (rec_len + 3) & ~3;
        idx = body_cnt;
        body_cnt++;
        if (idx < plen) begin
          res.kind = rrd_pkg::KIND_PAYLOAD;
          res.payload_byte = req.ring_byte;
          res.last_byte = (idx + 1 == plen);
          frame_exp_q.push_back(res);
        end else if (body_cnt >= span) begin
          // The record is done on its last CRC or padding byte. The next header sits
          // past the four-byte header and the padded body, wrapped to the ring.
          nxt = ((rec_base + ((rec_len + 7) & ~3)) % RING_SIZE) & ~3;
          rp = ((nxt + RING_SIZE - (PTR_BACKOFF % RING_SIZE)) % RING_SIZE) & ~3;
          rec_base = nxt[12:0];
          ph = rrd_pkg::PH_HDR0;
          body_cnt = 0;
          res.kind = rrd_pkg::KIND_DONE;
          res.payload_length = plen[12:0];
          res.next_offset = nxt[12:0];
          res.read_pointer = rp[12:0];
          frame_exp_q.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(rrd_pkg::out_res_t got);
    rrd_pkg::out_res_t want;
    if (frame_exp_q.size() == 0) begin
      $display("%0t: kind expected none, actual %0d", $time, got.kind);
      mismatches++;
      return;
    end
    want = frame_exp_q.pop_front();
    compare_field("kind", 16'(want.kind), 16'(got.kind));
    compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
    compare_field("last_byte", 16'(want.last_byte), 16'(got.last_byte));
    compare_field("payload_length", 16'(want.payload_length), 16'(got.payload_length));
    compare_field("next_offset", 16'(want.next_offset), 16'(got.next_offset));
    compare_field("read_pointer", 16'(want.read_pointer), 16'(got.read_pointer));
  endtask

  // Input driver. A request is taken at an edge where in_valid is high and in_stall
  // is low; the shadow parser is stepped right there. The next request goes out once
  // its idle cycles have passed, so in_valid only changes when the slot is free.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      held_cycles = 0;
      ph = rrd_pkg::PH_HDR0;
      body_cnt = 0;
      hdr_lo = '0;
      hdr_hi = '0;
      rec_len = '0;
      rec_base = '0;
    end else begin
      if (in_valid && !in_stall) predict_deframe(in_data);
      if (!in_valid || !in_stall) begin
        if (ring_q.size() != 0 && held_cycles >= ring_q[0].gap) begin
          in_valid <= 1'b1;
          in_data <= ring_q[0].req;
          void'(ring_q.pop_front());
          held_cycles = 0;
        end else begin
          in_valid <= 1'b0;
          if (ring_q.size() != 0) held_cycles++;
        end
      end
    end
  end

  // Result monitor. Each accepted result is checked against the oldest prediction,
  // and then the receiver draws how long it stalls before taking the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void push_item(logic [7:0] b, logic rs);
    ring_item_t item;
    item.req.ring_byte = b;
    item.req.restart = rs;
    item.gap = pick_gap();
    ring_q.push_back(item);
  endfunction

  // Queues one record: the four header bytes, then for a good header the padded body
  // with random content. A record cut short, or one with a bad header, is followed by
  // a restart request; a bad header also gets up to three bytes that must be dropped.
  function automatic void push_record(int len, logic [7:0] lo, logic [7:0] hi, bit good,
                                      int cut);
    int total;
    logic [15:0] len16;
    logic [7:0] b;
    len16 = len[15:0];
    total = good ? 4 + ((len + 3) & ~3) : 4;
    for (int i = 0; i < total; i++) begin
      if (i == cut) break;
      case (i)
        0: b = lo;
        1: b = hi;
        2: b = len16[7:0];
        3: b = len16[15:8];
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_item(b, 1'b0);
      stim_count++;
    end
    if (!good) begin
      repeat ($urandom_range(0, 3)) push_item(8'($urandom_range(0, 255)), 1'b0);
    end
    if (!good || cut >= 0) push_item(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // Mostly well-formed records of short length, with header errors of every kind,
  // records broken off by a restart, and lone restarts mixed in.
  function automatic void random_phase(int maxf, int budget);
    int target, pick, len, lim, total;
    logic [7:0] lo, hi;
    target = stim_count + budget;
    // A record right at a small frame limit, and one a byte beyond the limit.
    if (maxf <= 256) push_record(maxf + 4, rrd_pkg::STATUS_LOW_OK, 8'hFF, 1'b1, -1);
    push_record(maxf + 5, rrd_pkg::STATUS_LOW_OK, 8'h01, 1'b0, -1);
    while (stim_count < target) begin
      pick = $urandom_range(0, 99);
      hi = 8'($urandom_range(1, 255));
      lim = (maxf + 4 < 72) ? maxf + 4 : 72;
      len = $urandom_range(4, lim);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(4, (maxf + 4 < 300) ? maxf + 4 : 300);
      if (pick < 70) begin
        push_record(len, rrd_pkg::STATUS_LOW_OK, hi, 1'b1, -1);
      end else if (pick < 85) begin
        lo = rrd_pkg::STATUS_LOW_OK;
        case ($urandom_range(0, 4))
          0: lo = 8'($urandom_range(2, 255));
          1: lo = 8'h00;
          2: hi = 8'h00;
          3: len = $urandom_range(maxf + 5, 65535);
          default: len = $urandom_range(0, 3);
        endcase
        push_record(len, lo, hi, 1'b0, -1);
      end else if (pick < 93) begin
        total = 4 + ((len + 3) & ~3);
        push_record(len, rrd_pkg::STATUS_LOW_OK, hi, 1'b1, $urandom_range(1, total - 1));
      end else begin
        push_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endfunction

  // Holds the sender until every request is taken and every predicted result is in,
  // then lets a few cycles pass so a request without a result has left the block.
  task automatic wait_drained();
    while (ring_q.size() != 0 || in_valid || frame_exp_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the frame size limit: a setup cycle, then an access cycle that
  // completes at the edge where pready is seen high.
  task automatic write_max_frame(logic [12:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {rrd_pkg::REG_MAX_FRAME, 2'b00};
    pwdata <= {{(rrd_pkg::CFG_DATA_W - 13){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    max_frame = value;
  endtask

  initial begin
    int maxf;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed start with the reset limit: a restart while idle, a record with no payload,
    // a bad status byte followed by up to three dropped bytes, and a one-byte payload.
    push_item(8'hA5, 1'b1);
    push_record(4, rrd_pkg::STATUS_LOW_OK, 8'hFF, 1'b1, -1);
    push_record(4, 8'hFE, 8'h80, 1'b0, -1);
    push_record(5, rrd_pkg::STATUS_LOW_OK, 8'h01, 1'b1, -1);
    wait_drained();

    // Smallest limit.
    write_max_frame(13'd64);
    @(negedge clk);
    random_phase(64, 210);
    wait_drained();

    // Largest limit without idling on either side, which keeps requests and results
    // moving back to back. The first records sit just past ring offset zero, so the
    // read pointer wraps below the start of the ring.
    calm = 1'b1;
    write_max_frame(13'd8184);
    @(negedge clk);
    push_item(8'h00, 1'b1);
    push_record(4, rrd_pkg::STATUS_LOW_OK, 8'h01, 1'b1, -1);
    push_record(5, rrd_pkg::STATUS_LOW_OK, 8'hC3, 1'b1, -1);
    random_phase(8184, 150);
    wait_drained();
    calm = 1'b0;

    // Random limits around a return to the reset value.
    for (int k = 0; k < 3; k++) begin
      maxf = (k == 1) ? 1514 : $urandom_range(64, 8184);
      write_max_frame(maxf[12:0]);
      @(negedge clk);
      random_phase(maxf, 210);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
